@@ rtl/core/hsrd_pkg.sv @@
package hsrd_pkg;

  localparam int unsigned FRAME_LEN  = 6;
  localparam int unsigned MARK_COUNT = 3;
  localparam int unsigned BEAT_W     = 4;

  localparam logic [7:0] MARK_BYTE = 8'd83;

  localparam logic [1:0] KIND_HDR   = 2'd0;
  localparam logic [1:0] KIND_DIST  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;
  localparam logic [1:0] KIND_MARK  = 2'd3;

  localparam logic [1:0] CFG_SYNC_VALUE   = 2'd0;
  localparam logic [1:0] CFG_READINGS_PER = 2'd1;

  localparam logic [7:0]  SYNC_RESET = 8'd255;
  localparam logic [11:0] RPS_RESET  = 12'd2000;

  // Last beat of a frame without and with the scan end markers.
  localparam logic [BEAT_W-1:0] LAST_PLAIN = BEAT_W'(FRAME_LEN - 1);
  localparam logic [BEAT_W-1:0] LAST_MARK  = BEAT_W'(FRAME_LEN + MARK_COUNT - 1);

  // One matched frame handed from the front end to the back end.
  typedef struct packed {
    logic [FRAME_LEN-1:0][7:0] bytes;
    logic                      mark;
  } frame_t;

  function automatic logic [1:0] kind_of(input logic [2:0] pos);
    logic [1:0] k;
    case (pos)
      3'd0, 3'd1: k = KIND_HDR;
      3'd2, 3'd3: k = KIND_DIST;
      3'd4, 3'd5: k = KIND_ANGLE;
      default:    k = KIND_MARK;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/header_sync_reading_deframer_core.sv @@
// Sync-word deframer for a byte stream from a serial link.
// Input channel: in_valid_i / in_stall_o carry one received byte per request.
// Output channel: out_valid_o / out_stall_i carry one tagged byte per request
// with its kind (header, distance, angle, scan end marker) and a last flag
// that marks the final output of each frame.
// The front end takes one byte per cycle, unless stalled, into a five-byte
// window and tests it with the sixth byte once full. A matching frame goes
// into a two-entry queue; the back end then plays it out as six bytes, plus
// three 'S' markers when the frame count reaches the configured scan length.
// The first byte of a frame is offered once the frame has passed from the
// queue entry into the back end's frame register.
// Throughput: one byte per cycle in unless stalled; the back end emits one
// byte per cycle unless the receiver stalls, so a frame costs six or nine
// output bytes, and the queue depth sets how long input runs ahead of output.
// in_stall_o rises only while the queue holds two frames. When the receiver
// stalls, the current output holds and the queue fills.
// Reset empties the window, queue and frame count, restores the sync value to
// 255 and the scan length to 2000. The user must write configuration through
// cfg_we_i, cfg_idx_i and cfg_wdata_i while the block is idle (not enforced).
module header_sync_reading_deframer_core import hsrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  out_byte_kind_o,
  output logic        out_last_o
);

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  frame_t push_frame;
  frame_t head;

  // Holding off input whenever the queue is full keeps a push from ever
  // meeting a full queue.
  assign in_stall_o = full;

  hsrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (full),
    .in_byte_i    (in_byte_i),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  hsrd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .pop_i        (pop),
    .full_o       (full),
    .empty_o      (empty),
    .head_o       (head)
  );

  hsrd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .out_byte_kind_o (out_byte_kind_o),
    .out_last_o      (out_last_o)
  );

endmodule

@@ rtl/core/hsrd_front.sv @@
module hsrd_front import hsrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  output logic        push_o,
  output frame_t      push_frame_o
);

  logic [7:0]  sync_q, sync_d;
  logic [11:0] rps_q, rps_d;
  logic [2:0]  fill_q, fill_d;
  logic [11:0] cnt_q, cnt_d;
  logic [FRAME_LEN-2:0][7:0] win_q, win_d;
  logic        match;
  logic [11:0] cnt_inc;

  assign match = (win_q[0] == sync_q) && (win_q[1] == sync_q) && (win_q[2] != sync_q);
  assign cnt_inc = cnt_q + 12'd1;

  always_comb begin
    sync_d = sync_q;
    rps_d  = rps_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_VALUE:   sync_d = cfg_wdata_i[7:0];
        CFG_READINGS_PER: rps_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    push_o = 1'b0;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      push_frame_o.bytes[i] = win_q[i];
    end
    push_frame_o.bytes[FRAME_LEN-1] = in_byte_i;
    push_frame_o.mark = (cnt_inc == rps_q);
    if (in_valid_i && !in_stall_i) begin
      if (fill_q != 3'(FRAME_LEN - 1)) begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
          if (3'(i) == fill_q) begin
            win_d[i] = in_byte_i;
          end
        end
        fill_d = fill_q + 3'd1;
      end else if (match) begin
        push_o = 1'b1;
        fill_d = 3'd0;
        cnt_d  = push_frame_o.mark ? 12'd0 : cnt_inc;
      end else begin
        // Drop the oldest byte; the window stays full, one byte short of a frame.
        for (int i = 0; i < FRAME_LEN - 2; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[FRAME_LEN-2] = in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
      rps_q  <= RPS_RESET;
      fill_q <= 3'd0;
      cnt_q  <= 12'd0;
    end else begin
      sync_q <= sync_d;
      rps_q  <= rps_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

@@ rtl/core/hsrd_queue.sv @@
module hsrd_queue import hsrd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_frame_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output frame_t head_o
);

  frame_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/hsrd_back.sv @@
module hsrd_back import hsrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  frame_t     head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_byte_kind_o,
  output logic       out_last_o
);

  logic              busy_q;
  frame_t            frame_q;
  logic [BEAT_W-1:0] beat_q;
  logic              is_last;
  logic              is_frame;
  logic              done;

  assign is_frame = (beat_q < BEAT_W'(FRAME_LEN));
  assign is_last  = frame_q.mark ? (beat_q == LAST_MARK) : (beat_q == LAST_PLAIN);
  assign done     = busy_q && !out_stall_i && is_last;
  assign pop_o    = !empty_i && (!busy_q || done);

  assign out_valid_o     = busy_q;
  assign out_byte_o      = is_frame ? frame_q.bytes[beat_q[2:0]] : MARK_BYTE;
  assign out_byte_kind_o = is_frame ? kind_of(beat_q[2:0]) : KIND_MARK;
  assign out_last_o      = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      beat_q <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (busy_q && !out_stall_i) begin
      beat_q <= beat_q + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_q <= head_i;
    end
  end

endmodule
